// ===== rtl/dhcp_option_parser_defines.svh =====
// Assertion macros for the DHCP option parser checker.
// No dependencies; included by the checker file only.
`ifndef DHCP_OPTION_PARSER_DEFINES_SVH
`define DHCP_OPTION_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DOP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DOP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dop_pkg.sv =====
// Shared types and constants for the DHCP option parser.
// No dependencies; used by the interfaces, the top level and the checker.
package dop_pkg;

    localparam int DATA_W  = 8;
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 4;

    // option codes
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_MASK     = 8'd1;
    localparam logic [7:0] OPT_GATEWAY  = 8'd3;
    localparam logic [7:0] OPT_DNS      = 8'd6;
    localparam logic [7:0] OPT_HOSTNAME = 8'd12;
    localparam logic [7:0] OPT_DOMAIN   = 8'd15;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_SERVER   = 8'd54;
    localparam logic [7:0] OPT_RENEWAL  = 8'd58;
    localparam logic [7:0] OPT_REBIND   = 8'd59;
    localparam logic [7:0] OPT_END      = 8'd255;

    localparam logic [VALUE_W-1:0] SECS_MAX      = 32'h0000_FFFF;
    localparam logic [VALUE_W-1:0] SECS_INFINITE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2,
        PH_DRAIN = 2'd3
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 4'd0,
        KIND_MASK     = 4'd1,
        KIND_GATEWAY  = 4'd2,
        KIND_DNS      = 4'd3,
        KIND_HOST     = 4'd4,
        KIND_DOMAIN   = 4'd5,
        KIND_LEASE    = 4'd6,
        KIND_RENEWAL  = 4'd7,
        KIND_REBIND   = 4'd8,
        KIND_MSG_TYPE = 4'd9,
        KIND_SERVER   = 4'd10
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic [7:0]         position;
        logic               infinite;
        logic               done_res;
        logic               saw_command;
    } t_record;

endpackage

// ===== rtl/dop_if.sv =====
// Valid/ready channel interfaces for option bytes in and records out.
// Depends on dop_pkg for field widths.
interface dop_byte_if;
    import dop_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dop_rec_if;
    import dop_pkg::*;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [7:0]         position;
    logic               infinite;
    logic               done_res;
    logic               saw_command;

    modport source (output valid, output kind, output value, output position,
                    output infinite, output done_res, output saw_command, input ready);
    modport sink   (input valid, input kind, input value, input position,
                    input infinite, input done_res, input saw_command, output ready);
endinterface

// ===== rtl/dhcp_option_parser.sv =====
// DHCP option parser top level: byte-serial walker of a BOOTP/DHCP option area.
// Depends on dop_pkg and the channel interfaces in dop_if.sv.
//
// Feed the option area one byte per transfer, starting right after the magic
// cookie, and mark the final byte of the reply with last_byte. The block walks
// code/length/value records, skips pad bytes and stops at the end code. For each
// recognized option it emits one typed record: the subnet mask, every gateway or
// name server word (big-endian, indexed by position), every hostname or domain
// character, lease, renewal and rebind seconds (clamped to 65535; lease and
// renewal of all ones come back as infinite with value 0), the message type and
// a nonzero server id. Trailing partial words are dropped. The transfer that
// finishes parsing (end code or last byte) carries done_res and saw_command,
// merged with a record if that byte completes one. After an end code, bytes up
// to and including the last byte are swallowed without output. Throughput is
// one byte per clock: the whole per-byte update is one pass of logic from the
// parser state into the output record register, and a byte is taken whenever
// that register is empty or being drained in the same cycle, so a byte's record
// appears in the cycle after its transfer.
module dhcp_option_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dop_byte_if.sink  i_byte,
    dop_rec_if.source o_rec
);
    import dop_pkg::*;

    // parser state
    t_phase             r_phase,  n_phase;
    logic [7:0]         r_code,   n_code;
    logic [7:0]         r_len,    n_len;
    logic [7:0]         r_count,  n_count;
    logic [VALUE_W-1:0] r_acc,    n_acc;
    logic               r_cmd,    n_cmd;

    // output record register
    logic               r_out_valid;
    t_record            r_out, n_out;
    logic               have, done;

    logic               accept;
    logic [7:0]         b;
    logic               last;
    logic [7:0]         cnt_inc;
    logic [VALUE_W-1:0] acc_shift;
    logic [VALUE_W-1:0] acc_clamp;

    assign b         = i_byte.data_byte;
    assign last      = i_byte.last_byte;
    assign cnt_inc   = r_count + 8'd1;
    assign acc_shift = {r_acc[VALUE_W-9:0], b};
    assign acc_clamp = (acc_shift > SECS_MAX) ? SECS_MAX : acc_shift;

    // take a byte when the record register is free this cycle
    assign i_byte.ready = !r_out_valid || o_rec.ready;
    assign accept       = i_byte.valid && i_byte.ready;

    always_comb begin
        n_phase = r_phase;
        n_code  = r_code;
        n_len   = r_len;
        n_count = r_count;
        n_acc   = r_acc;
        n_cmd   = r_cmd;
        have    = 1'b0;
        done    = 1'b0;
        n_out   = '{kind: KIND_NONE, value: '0, position: '0,
                    infinite: 1'b0, done_res: 1'b0, saw_command: 1'b0};

        case (r_phase)
            PH_CODE: begin
                if (b == OPT_END) begin
                    done = 1'b1;
                end else if (b != OPT_PAD) begin
                    n_code  = b;
                    n_count = '0;
                    n_acc   = '0;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_len   = b;
                n_count = '0;
                n_acc   = '0;
                n_phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
            end
            PH_VALUE: begin
                n_acc   = acc_shift;
                n_count = cnt_inc;
                case (r_code)
                    OPT_MASK: begin
                        if (cnt_inc == 8'd4 && r_len >= 8'd4) begin
                            have        = 1'b1;
                            n_out.kind  = KIND_MASK;
                            n_out.value = acc_shift;
                        end
                    end
                    OPT_GATEWAY, OPT_DNS: begin
                        if (cnt_inc[1:0] == 2'b00) begin
                            have           = 1'b1;
                            n_out.kind     = (r_code == OPT_GATEWAY) ? KIND_GATEWAY : KIND_DNS;
                            n_out.value    = acc_shift;
                            n_out.position = {2'b00, cnt_inc[7:2]} - 8'd1;
                        end
                    end
                    OPT_HOSTNAME, OPT_DOMAIN: begin
                        have           = 1'b1;
                        n_out.kind     = (r_code == OPT_HOSTNAME) ? KIND_HOST : KIND_DOMAIN;
                        n_out.value    = {{(VALUE_W-8){1'b0}}, b};
                        n_out.position = cnt_inc - 8'd1;
                    end
                    OPT_LEASE, OPT_RENEWAL: begin
                        if (cnt_inc == 8'd4 && r_len == 8'd4) begin
                            have       = 1'b1;
                            n_out.kind = (r_code == OPT_LEASE) ? KIND_LEASE : KIND_RENEWAL;
                            if (acc_shift == SECS_INFINITE) begin
                                n_out.infinite = 1'b1;
                            end else begin
                                n_out.value = acc_clamp;
                            end
                        end
                    end
                    OPT_REBIND: begin
                        if (cnt_inc == 8'd4 && r_len == 8'd4) begin
                            have        = 1'b1;
                            n_out.kind  = KIND_REBIND;
                            n_out.value = acc_clamp;
                        end
                    end
                    OPT_MSG_TYPE: begin
                        if (cnt_inc == 8'd1) begin
                            have        = 1'b1;
                            n_out.kind  = KIND_MSG_TYPE;
                            n_out.value = {{(VALUE_W-8){1'b0}}, b};
                            n_cmd       = 1'b1;
                        end
                    end
                    OPT_SERVER: begin
                        if (cnt_inc == 8'd4 && r_len == 8'd4 && acc_shift != '0) begin
                            have        = 1'b1;
                            n_out.kind  = KIND_SERVER;
                            n_out.value = acc_shift;
                        end
                    end
                    default: ;
                endcase
                if (cnt_inc >= r_len) begin
                    n_phase = PH_CODE;
                end
            end
            default: ;  // drain: swallow bytes until the last one
        endcase

        if (r_phase != PH_DRAIN && last) begin
            done = 1'b1;
        end
        n_out.done_res    = done;
        n_out.saw_command = done && n_cmd;

        // finish: back to reset on the last byte, else drain the rest
        if (r_phase == PH_DRAIN) begin
            if (last) begin
                n_phase = PH_CODE;
                n_code  = '0;
                n_len   = '0;
                n_count = '0;
                n_acc   = '0;
                n_cmd   = 1'b0;
            end
        end else if (done) begin
            if (last) begin
                n_phase = PH_CODE;
                n_code  = '0;
                n_len   = '0;
                n_count = '0;
                n_acc   = '0;
                n_cmd   = 1'b0;
            end else begin
                n_phase = PH_DRAIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CODE;
            r_code      <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_acc       <= '0;
            r_cmd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_code      <= n_code;
                r_len       <= n_len;
                r_count     <= n_count;
                r_acc       <= n_acc;
                r_cmd       <= n_cmd;
                r_out_valid <= have || done;
            end else if (o_rec.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload register: load only with a record to show
    always_ff @(posedge i_clk) begin
        if (accept && (have || done)) begin
            r_out <= n_out;
        end
    end

    assign o_rec.valid       = r_out_valid;
    assign o_rec.kind        = r_out.kind;
    assign o_rec.value       = r_out.value;
    assign o_rec.position    = r_out.position;
    assign o_rec.infinite    = r_out.infinite;
    assign o_rec.done_res    = r_out.done_res;
    assign o_rec.saw_command = r_out.saw_command;

endmodule

// ===== rtl/dop_checker.sv =====
// Port-level assertions for the DHCP option parser, bound to the top level.
// Depends on dop_pkg and dhcp_option_parser_defines.svh.
`include "dhcp_option_parser_defines.svh"

module dop_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [dop_pkg::KIND_W-1:0]  i_kind,
    input logic [dop_pkg::VALUE_W-1:0] i_value,
    input logic [7:0]                  i_position,
    input logic                        i_infinite,
    input logic                        i_done_res,
    input logic                        i_saw_command
);
    import dop_pkg::*;

    // an empty record only ever marks the end of parsing
    `DOP_ASSERT_NOW(a_none_is_done, i_out_valid && i_kind == KIND_NONE, i_done_res,
        "record of kind none without done_res")

    `DOP_ASSERT_NOW(a_cmd_with_done, i_out_valid && i_saw_command, i_done_res,
        "saw_command shown without done_res")

    `DOP_ASSERT_NOW(a_infinite_kind, i_out_valid && i_infinite,
        (i_kind == KIND_LEASE || i_kind == KIND_RENEWAL) && i_value == '0,
        "infinite flag on a record that is not lease or renewal")

    `DOP_ASSERT_NOW(a_position_zero,
        i_out_valid && !(i_kind == KIND_GATEWAY || i_kind == KIND_DNS ||
                         i_kind == KIND_HOST || i_kind == KIND_DOMAIN),
        i_position == 8'd0,
        "nonzero position on a record kind without an index")

    // a stalled record holds its contents
    `DOP_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_value) && $stable(i_kind),
        "stalled record changed")

endmodule

bind dhcp_option_parser dop_checker u_dop_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rec.valid),
    .i_out_ready   (o_rec.ready),
    .i_kind        (o_rec.kind),
    .i_value       (o_rec.value),
    .i_position    (o_rec.position),
    .i_infinite    (o_rec.infinite),
    .i_done_res    (o_rec.done_res),
    .i_saw_command (o_rec.saw_command)
);

// ===== tb/sv/tb_dhcp_option_parser.sv =====
`timescale 1ns / 100ps
// Self-checking bench for dhcp_option_parser: a directed table of option bytes, then random
// option areas, all checked record by record. Depends on dop_pkg, dop_if.sv and the RTL.
module tb_dhcp_option_parser;
    import dop_pkg::*;

    localparam int WALK_TARGET   = 800;        // option bytes walked (drained bytes excluded)
    localparam int IDLE_PERCENT  = 14;
    localparam int HOLD_START    = 300;        // receiver cycle at which the long hold begins
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 10;
    localparam int PAUSE_AREA    = 15;         // sender waits for every record before this area
    localparam int STEADY_FIRST  = 22;         // areas run with no idling on either side
    localparam int STEADY_LAST   = 30;
    localparam int TIMEOUT_NS    = 40_000_000;

    // How a transfer is checked: by the predictor, by a record typed into the table,
    // or as a transfer that must not produce any record.
    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SILENT} t_row_check;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_row_check check;
        t_record    rec;
    } t_offer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dop_byte_if byte_ch ();
    dop_rec_if  rec_ch ();

    dhcp_option_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_rec   (rec_ch)
    );

    always #10 i_clk = ~i_clk;

    // Option walker state, mirrored from the block's behavior.
    t_phase      walk_phase;
    logic [7:0]  cur_code;
    logic [7:0]  cur_len;
    logic [7:0]  byte_count;
    logic [31:0] word_acc;
    logic        msg_type_seen;

    t_record     expected_records[$];
    t_offer      offer;                        // what the source drives right now
    int unsigned fail_count   = 0;
    int unsigned walked_bytes = 0;
    bit          steady_run   = 1'b0;

    function automatic void clear_walk();
        walk_phase    = PH_CODE;
        cur_code      = 8'd0;
        cur_len       = 8'd0;
        byte_count    = 8'd0;
        word_acc      = 32'd0;
        msg_type_seen = 1'b0;
    endfunction

    function automatic logic [31:0] clamp_secs(input logic [31:0] v);
        return (v > SECS_MAX) ? SECS_MAX : v;
    endfunction

    // Advance the walker by one byte; return 1 with the record when the byte yields one.
    function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                        output t_record rec);
        logic [7:0] n;
        bit         have;
        bit         done;
        have = 1'b0;
        done = 1'b0;
        rec  = '0;
        case (walk_phase)
            PH_CODE: begin
                if (b == OPT_END) begin
                    done = 1'b1;
                end else if (b != OPT_PAD) begin
                    cur_code   = b;
                    byte_count = 8'd0;
                    word_acc   = 32'd0;
                    walk_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                cur_len    = b;
                byte_count = 8'd0;
                word_acc   = 32'd0;
                walk_phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
            end
            PH_VALUE: begin
                // Shift the byte in big-endian and count it against the option length.
                word_acc   = {word_acc[23:0], b};
                byte_count = byte_count + 8'd1;
                n          = byte_count;
                case (cur_code)
                    OPT_MASK: begin
                        if (n == 8'd4 && cur_len >= 8'd4) begin
                            have      = 1'b1;
                            rec.kind  = KIND_MASK;
                            rec.value = word_acc;
                        end
                    end
                    OPT_GATEWAY, OPT_DNS: begin
                        if (n[1:0] == 2'b00) begin
                            have         = 1'b1;
                            rec.kind     = (cur_code == OPT_GATEWAY) ? KIND_GATEWAY : KIND_DNS;
                            rec.value    = word_acc;
                            rec.position = (n >> 2) - 8'd1;
                        end
                    end
                    OPT_HOSTNAME, OPT_DOMAIN: begin
                        have         = 1'b1;
                        rec.kind     = (cur_code == OPT_HOSTNAME) ? KIND_HOST : KIND_DOMAIN;
                        rec.value    = {24'd0, b};
                        rec.position = n - 8'd1;
                    end
                    OPT_LEASE, OPT_RENEWAL: begin
                        if (n == 8'd4 && cur_len == 8'd4) begin
                            have     = 1'b1;
                            rec.kind = (cur_code == OPT_LEASE) ? KIND_LEASE : KIND_RENEWAL;
                            if (word_acc == SECS_INFINITE) rec.infinite = 1'b1;
                            else rec.value = clamp_secs(word_acc);
                        end
                    end
                    OPT_REBIND: begin
                        if (n == 8'd4 && cur_len == 8'd4) begin
                            have      = 1'b1;
                            rec.kind  = KIND_REBIND;
                            rec.value = clamp_secs(word_acc);
                        end
                    end
                    OPT_MSG_TYPE: begin
                        if (n == 8'd1) begin
                            have          = 1'b1;
                            rec.kind      = KIND_MSG_TYPE;
                            rec.value     = {24'd0, b};
                            msg_type_seen = 1'b1;
                        end
                    end
                    OPT_SERVER: begin
                        if (n == 8'd4 && cur_len == 8'd4 && word_acc != 32'd0) begin
                            have      = 1'b1;
                            rec.kind  = KIND_SERVER;
                            rec.value = word_acc;
                        end
                    end
                    default: ;
                endcase
                if (n >= cur_len) walk_phase = PH_CODE;
            end
            default: begin
                // Swallow bytes after an end code; the last byte rearms the walker.
                if (last) clear_walk();
                return 1'b0;
            end
        endcase
        if (last) done = 1'b1;
        if (!have && !done) return 1'b0;
        rec.done_res    = done;
        rec.saw_command = done & msg_type_seen;
        if (done) begin
            if (last) clear_walk();
            else walk_phase = PH_DRAIN;
        end
        return 1'b1;
    endfunction

    function automatic t_record rec_of(input t_kind kind, input logic [31:0] value,
                                       input logic inf, input logic done, input logic saw);
        t_record r;
        r             = '0;
        r.kind        = kind;
        r.value       = value;
        r.infinite    = inf;
        r.done_res    = done;
        r.saw_command = saw;
        return r;
    endfunction

    function automatic t_offer make_row(input logic [7:0] b, input logic last,
                                        input t_row_check chk, input t_record rec);
        t_offer o;
        o.data  = b;
        o.last  = last;
        o.check = chk;
        o.rec   = rec;
        return o;
    endfunction

    function automatic bit field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Scoreboard: predict on each input transfer, check on each output transfer.
    // Sample at the rising edge; the sources change only on the falling edge.
    always @(posedge i_clk) begin : scoreboard
        t_record predicted;
        t_record want;
        bit      produced;
        bit      bad;
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready) begin
                if (walk_phase != PH_DRAIN) walked_bytes++;
                produced = predict_byte(byte_ch.data_byte, byte_ch.last_byte, predicted);
                case (offer.check)
                    ROW_TYPED:   expected_records.push_back(offer.rec);
                    ROW_PREDICT: if (produced) expected_records.push_back(predicted);
                    default: ;  // silent row: any record that shows up is unexpected
                endcase
            end
            if (rec_ch.valid && rec_ch.ready) begin
                if (expected_records.size() == 0) begin
                    $error("record with none expected: kind %0d value %0h",
                           rec_ch.kind, rec_ch.value);
                    fail_count++;
                end else begin
                    want = expected_records.pop_front();
                    bad  = field_differs("kind", 32'(want.kind), 32'(rec_ch.kind));
                    bad |= field_differs("value", want.value, rec_ch.value);
                    bad |= field_differs("position", 32'(want.position),
                                         32'(rec_ch.position));
                    bad |= field_differs("infinite", 32'(want.infinite),
                                         32'(rec_ch.infinite));
                    bad |= field_differs("done_res", 32'(want.done_res),
                                         32'(rec_ch.done_res));
                    bad |= field_differs("saw_command", 32'(want.saw_command),
                                         32'(rec_ch.saw_command));
                    if (bad) fail_count++;
                end
            end
        end
    end

    // Record sink: random back-pressure, plus one long hold counted here so that the
    // output register fills and the parser has to stall its byte input.
    initial begin : record_sink
        int unsigned cycle_no;
        int unsigned hold_left;
        cycle_no     = 0;
        hold_left    = 0;
        rec_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cycle_no++;
            if (cycle_no == HOLD_START) hold_left = HOLD_CYCLES;
            if (hold_left != 0) begin
                hold_left--;
                rec_ch.ready <= 1'b0;
            end else begin
                rec_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Drive one byte: idle at random first, then hold it until the transfer happens.
    // Enter and leave on a falling edge.
    task automatic offer_byte(input t_offer it);
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        offer = it;
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= it.data;
        byte_ch.last_byte <= it.last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Build one random option area and send it. Most areas are well formed with random
    // content; some bend lengths, get cut off mid-record, or are pure noise.
    task automatic send_area();
        logic [7:0]  area[$];
        logic [7:0]  code;
        logic [31:0] word;
        int unsigned n_opts;
        int unsigned len;
        int unsigned pick;
        int unsigned n_bytes;
        int unsigned k;
        int unsigned j;
        int unsigned i;
        t_offer      it;
        word   = 32'd0;
        n_opts = $urandom_range(1, 5);
        for (k = 0; k < n_opts; k++) begin
            case ($urandom_range(0, 11))
                0:       code = OPT_PAD;
                1:       code = OPT_MASK;
                2:       code = OPT_GATEWAY;
                3:       code = OPT_DNS;
                4:       code = OPT_HOSTNAME;
                5:       code = OPT_DOMAIN;
                6:       code = OPT_LEASE;
                7:       code = OPT_MSG_TYPE;
                8:       code = OPT_SERVER;
                9:       code = OPT_RENEWAL;
                10:      code = OPT_REBIND;
                default: code = 8'($urandom_range(1, 254));
            endcase
            area.push_back(code);
            if (code != OPT_PAD) begin
                case (code)
                    OPT_GATEWAY, OPT_DNS:     len = 4 * $urandom_range(1, 3);
                    OPT_HOSTNAME, OPT_DOMAIN: len = $urandom_range(1, 12);
                    OPT_MSG_TYPE:             len = 1;
                    OPT_MASK, OPT_LEASE, OPT_RENEWAL, OPT_REBIND, OPT_SERVER: len = 4;
                    default:                  len = $urandom_range(0, 6);
                endcase
                // Bend the length now and then: zero, short, odd, or the longest record.
                pick = $urandom_range(0, 99);
                if (pick < 2) len = 255;
                else if (pick < 15) len = $urandom_range(0, 9);
                area.push_back(8'(len));
                for (j = 0; j < len; j++) begin
                    // Favor the words that hit the clamp, the infinite flag and zero ids.
                    if (j % 4 == 0) begin
                        case ($urandom_range(0, 7))
                            0:       word = 32'd0;
                            1:       word = SECS_INFINITE;
                            2:       word = SECS_MAX;
                            3:       word = SECS_MAX + 32'd1;
                            4:       word = SECS_INFINITE - 32'd1;
                            default: word = $urandom;
                        endcase
                    end
                    area.push_back(word[8 * (3 - j % 4) +: 8]);
                end
            end
        end
        n_bytes = area.size();
        pick    = $urandom_range(0, 9);
        if (pick < 6) begin
            // Close with an end code, sometimes followed by bytes that must be swallowed.
            area.push_back(OPT_END);
            repeat ($urandom_range(0, 3)) area.push_back(8'($urandom));
            n_bytes = area.size();
        end else if (pick < 9) begin
            // Flag the last byte somewhere inside, possibly in the middle of a record.
            n_bytes = $urandom_range(1, area.size());
        end else begin
            area.delete();
            repeat ($urandom_range(1, 10)) area.push_back(8'($urandom));
            n_bytes = area.size();
        end
        for (i = 0; i < n_bytes; i++) begin
            it       = '0;
            it.data  = area[i];
            it.last  = (i == n_bytes - 1);
            it.check = ROW_PREDICT;
            offer_byte(it);
        end
    endtask

    // Main sequence: reset, directed table, random areas, drain, verdict.
    initial begin : byte_source
        t_offer      rows[$];
        int unsigned area_no;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'd0;
        byte_ch.last_byte = 1'b0;
        offer             = '0;
        clear_walk();
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Typed records can be read straight off the option layout.
        rows.push_back(make_row(OPT_PAD, 1'b0, ROW_SILENT, '0));      // pad is skipped
        // message type: record on the first value byte, no done yet
        rows.push_back(make_row(OPT_MSG_TYPE, 1'b0, ROW_SILENT, '0));
        rows.push_back(make_row(8'd1, 1'b0, ROW_SILENT, '0));
        rows.push_back(make_row(8'd7, 1'b0, ROW_TYPED,
                                rec_of(KIND_MSG_TYPE, 32'd7, 1'b0, 1'b0, 1'b0)));
        // lease of all ones: infinite, value zero
        rows.push_back(make_row(OPT_LEASE, 1'b0, ROW_SILENT, '0));
        rows.push_back(make_row(8'd4, 1'b0, ROW_SILENT, '0));
        repeat (3) rows.push_back(make_row(8'hFF, 1'b0, ROW_SILENT, '0));
        rows.push_back(make_row(8'hFF, 1'b0, ROW_TYPED,
                                rec_of(KIND_LEASE, 32'd0, 1'b1, 1'b0, 1'b0)));
        // rebind of all ones is never infinite: it clamps
        rows.push_back(make_row(OPT_REBIND, 1'b0, ROW_SILENT, '0));
        rows.push_back(make_row(8'd4, 1'b0, ROW_SILENT, '0));
        repeat (3) rows.push_back(make_row(8'hFF, 1'b0, ROW_SILENT, '0));
        rows.push_back(make_row(8'hFF, 1'b0, ROW_TYPED,
                                rec_of(KIND_REBIND, SECS_MAX, 1'b0, 1'b0, 1'b0)));
        // zero-length gateway yields nothing
        rows.push_back(make_row(OPT_GATEWAY, 1'b0, ROW_SILENT, '0));
        rows.push_back(make_row(8'd0, 1'b0, ROW_SILENT, '0));
        // host character on the last byte: record and done merged, message type seen
        rows.push_back(make_row(OPT_HOSTNAME, 1'b0, ROW_SILENT, '0));
        rows.push_back(make_row(8'd1, 1'b0, ROW_SILENT, '0));
        rows.push_back(make_row(8'h80, 1'b1, ROW_TYPED,
                                rec_of(KIND_HOST, 32'h80, 1'b0, 1'b1, 1'b1)));
        // end code before the last byte, then drained bytes up to the last one
        rows.push_back(make_row(OPT_END, 1'b0, ROW_TYPED,
                                rec_of(KIND_NONE, 32'd0, 1'b0, 1'b1, 1'b0)));
        rows.push_back(make_row(8'd0, 1'b0, ROW_SILENT, '0));
        rows.push_back(make_row(8'hFF, 1'b1, ROW_SILENT, '0));
        // last byte with no record of its own
        rows.push_back(make_row(OPT_MASK, 1'b1, ROW_TYPED,
                                rec_of(KIND_NONE, 32'd0, 1'b0, 1'b1, 1'b0)));
        foreach (rows[r]) offer_byte(rows[r]);

        area_no = 0;
        while (walked_bytes < WALK_TARGET) begin
            steady_run = (area_no >= STEADY_FIRST && area_no <= STEADY_LAST);
            if (area_no == PAUSE_AREA) begin
                // Hold the source until every outstanding record has been taken.
                byte_ch.valid <= 1'b0;
                do @(negedge i_clk); while (expected_records.size() != 0);
            end
            send_area();
            area_no++;
        end
        steady_run = 1'b0;

        byte_ch.valid <= 1'b0;
        do @(negedge i_clk); while (expected_records.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dop_pkg.sv
rtl/dop_if.sv
rtl/dhcp_option_parser.sv
rtl/dop_checker.sv
tb/sv/tb_dhcp_option_parser.sv
